>>> hw/rtl/cfpg_pkg.sv
// ----------------------------------------------------------------------------
// cfpg_pkg
// Shared types and constants of the channel-state frame packer: the request
// and response words, the frame opcodes and the fixed frame layout.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpg_pkg;

   // Payload limit and the width of a clipped length or a sample count.
   localparam int MAX_PAYLOAD = 1024;
   localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

   // Gain loaded at reset: 1.0 in unsigned Q8.8.
   localparam logic [15:0] UNITY_GAIN = 16'd256;

   // Frame magic, ASCII "CSI1".
   localparam logic [7:0] MAGIC_0 = 8'h43;
   localparam logic [7:0] MAGIC_1 = 8'h53;
   localparam logic [7:0] MAGIC_2 = 8'h49;
   localparam logic [7:0] MAGIC_3 = 8'h31;

   // Byte position within the burst that one request word causes.
   localparam int IDX_W = 4;
   localparam logic [IDX_W-1:0] IDX_MAGIC_0   = 4'd0;
   localparam logic [IDX_W-1:0] IDX_MAGIC_1   = 4'd1;
   localparam logic [IDX_W-1:0] IDX_MAGIC_2   = 4'd2;
   localparam logic [IDX_W-1:0] IDX_MAGIC_3   = 4'd3;
   localparam logic [IDX_W-1:0] IDX_SEQ_0     = 4'd4;
   localparam logic [IDX_W-1:0] IDX_SEQ_1     = 4'd5;
   localparam logic [IDX_W-1:0] IDX_SEQ_2     = 4'd6;
   localparam logic [IDX_W-1:0] IDX_SEQ_3     = 4'd7;
   localparam logic [IDX_W-1:0] IDX_LEN_LO    = 4'd8;
   localparam logic [IDX_W-1:0] IDX_LEN_HI    = 4'd9;
   localparam logic [IDX_W-1:0] IDX_HDR_SUM_LO = 4'd10;
   localparam logic [IDX_W-1:0] IDX_HDR_SUM_HI = 4'd11;
   localparam logic [IDX_W-1:0] IDX_PAY        = 4'd0;
   localparam logic [IDX_W-1:0] IDX_PAY_SUM_LO = 4'd1;

   typedef enum logic [0:0] {
      OP_START  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [31:0]        seq;
      logic [15:0]        length;
      logic [15:0]        gain;
      logic signed [7:0]  sample;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> hw/rtl/csi_frame_packer_with_gain.sv
// ----------------------------------------------------------------------------
// csi_frame_packer_with_gain
// Packs channel-state samples into byte frames with a header, gain-scaled
// payload bytes and a 16-bit byte-sum checksum.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req_word) takes start words
//   and sample words. The response channel (rsp_valid, rsp_stall, rsp_word)
//   delivers one frame byte per word, with run_last on the final byte that
//   a request word causes and frame_end on the closing checksum byte.
//   A request word sits in a one-deep item register while its bytes are
//   sent; each byte then passes into the output register, so a request
//   reaches the response through both registers. A sample word sends one
//   byte (three when it closes the frame), a start word ten bytes (twelve
//   for an empty frame); the byte sequencer sends one byte per cycle while
//   the output register is free. A sample that arrives with no frame open
//   is dropped and sends no byte. The next request word is accepted in the
//   cycle the last byte of the current one moves into the output register,
//   so samples stream at one word per cycle while rsp_stall is low and no
//   sample closes the frame. While rsp_stall is high the output byte holds
//   and the request side stalls once its item register is busy. Reset
//   empties both registers, closes any frame and restores unity gain.
// ----------------------------------------------------------------------------
`default_nettype none

module csi_frame_packer_with_gain (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire cfpg_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output cfpg_pkg::rsp_word_type     rsp_word
);

   import cfpg_pkg::*;

   typedef struct packed {
      op_type           op;
      logic [31:0]      seq;
      logic [LEN_W-1:0] len;
      logic [7:0]       pay_byte;
   } item_type;

   // Item register and byte sequencer.
   logic             item_vld_ff, item_vld_in;
   item_type         item_ff, item_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // Frame state.
   logic [LEN_W-1:0] samples_left_ff, samples_left_in;
   logic [15:0]      byte_sum_ff, byte_sum_in;
   logic [15:0]      frame_gain_ff, frame_gain_in;

   // Output register.
   logic             rsp_vld_ff, rsp_vld_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             req_acc;
   logic [7:0]       scaled;
   logic [LEN_W-1:0] len_clip;
   logic             out_free;
   logic             emit_go;
   logic             item_done;
   logic             drop;
   logic             last;
   logic             frame_end;
   logic             add_sum;
   logic [7:0]       byte_val;
   logic [7:0]       hdr_byte;
   logic [15:0]      len16;
   logic [15:0]      sum_base;

   // Scale the incoming sample with the gain of the current frame.
   cfpg_scale u_scale (
      .gain   (frame_gain_ff),
      .sample (req_word.sample),
      .scaled (scaled)
   );

   // Clip the requested length.
   assign len_clip = (req_word.length > 16'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                         : req_word.length[LEN_W-1:0];

   // Capture a new request word.
   assign req_acc         = req_valid && !req_stall;
   assign item_in.op      = req_word.op;
   assign item_in.seq     = req_word.seq;
   assign item_in.len     = len_clip;
   assign item_in.pay_byte = scaled;

   // Header byte selection.
   assign len16 = 16'(item_ff.len);
   always_comb begin
      unique case (idx_ff)
         IDX_MAGIC_0: hdr_byte = MAGIC_0;
         IDX_MAGIC_1: hdr_byte = MAGIC_1;
         IDX_MAGIC_2: hdr_byte = MAGIC_2;
         IDX_MAGIC_3: hdr_byte = MAGIC_3;
         IDX_SEQ_0:   hdr_byte = item_ff.seq[7:0];
         IDX_SEQ_1:   hdr_byte = item_ff.seq[15:8];
         IDX_SEQ_2:   hdr_byte = item_ff.seq[23:16];
         IDX_SEQ_3:   hdr_byte = item_ff.seq[31:24];
         IDX_LEN_LO:  hdr_byte = len16[7:0];
         IDX_LEN_HI:  hdr_byte = len16[15:8];
         default:     hdr_byte = 8'd0;
      endcase
   end

   // Decide what the current byte position sends and whether it ends the burst.
   always_comb begin
      drop      = 1'b0;
      last      = 1'b0;
      frame_end = 1'b0;
      add_sum   = 1'b0;
      byte_val  = 8'd0;
      if (item_ff.op == OP_START) begin
         if (idx_ff <= IDX_LEN_HI) begin
            byte_val = hdr_byte;
            add_sum  = 1'b1;
            last     = (idx_ff == IDX_LEN_HI) && (item_ff.len != '0);
         end else if (idx_ff == IDX_HDR_SUM_LO) begin
            byte_val = byte_sum_ff[7:0];
         end else begin
            byte_val  = byte_sum_ff[15:8];
            frame_end = 1'b1;
            last      = 1'b1;
         end
      end else begin
         if (idx_ff == IDX_PAY) begin
            drop     = (samples_left_ff == '0);
            byte_val = item_ff.pay_byte;
            add_sum  = 1'b1;
            last     = (samples_left_ff != LEN_W'(1));
         end else if (idx_ff == IDX_PAY_SUM_LO) begin
            byte_val = byte_sum_ff[7:0];
         end else begin
            byte_val  = byte_sum_ff[15:8];
            frame_end = 1'b1;
            last      = 1'b1;
         end
      end
   end

   // Handshake between the item register and the output register.
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign emit_go   = item_vld_ff && !drop && out_free;
   assign item_done = item_vld_ff && (drop || (emit_go && last));
   assign req_stall = item_vld_ff && !item_done;

   always_comb begin
      item_vld_in = item_vld_ff;
      idx_in      = idx_ff;
      if (item_done) begin
         item_vld_in = 1'b0;
         idx_in      = '0;
      end else if (emit_go) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (req_acc) begin
         item_vld_in = 1'b1;
      end
   end

   // Frame state updates as bytes leave; the frame gain is loaded when a start word is accepted.
   assign sum_base = ((item_ff.op == OP_START) && (idx_ff == IDX_MAGIC_0)) ? 16'd0
                                                                         : byte_sum_ff;
   always_comb begin
      byte_sum_in     = byte_sum_ff;
      samples_left_in = samples_left_ff;
      frame_gain_in   = frame_gain_ff;
      if (emit_go && add_sum) begin
         byte_sum_in = sum_base + 16'(byte_val);
      end
      if (emit_go && (item_ff.op == OP_START) && (idx_ff == IDX_MAGIC_0)) begin
         samples_left_in = item_ff.len;
      end else if (emit_go && (item_ff.op == OP_SAMPLE) && (idx_ff == IDX_PAY)) begin
         samples_left_in = samples_left_ff - LEN_W'(1);
      end
      if (req_acc && (req_word.op == OP_START)) begin
         frame_gain_in = req_word.gain;
      end
   end

   // Output register next value.
   assign rsp_word_in.out_byte  = byte_val;
   assign rsp_word_in.frame_end = frame_end;
   assign rsp_word_in.run_last  = last;
   assign rsp_vld_in = emit_go ? 1'b1 : (rsp_vld_ff && rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff     <= 1'b0;
         idx_ff          <= '0;
         samples_left_ff <= '0;
         byte_sum_ff     <= 16'd0;
         frame_gain_ff   <= UNITY_GAIN;
         rsp_vld_ff      <= 1'b0;
      end else begin
         item_vld_ff     <= item_vld_in;
         idx_ff          <= idx_in;
         samples_left_ff <= samples_left_in;
         byte_sum_ff     <= byte_sum_in;
         frame_gain_ff   <= frame_gain_in;
         rsp_vld_ff      <= rsp_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         item_ff <= item_in;
      end
      if (emit_go) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_word_ff;

   // The closing checksum byte always ends the burst of its request word.
   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_word_ff.frame_end |-> rsp_word_ff.run_last)
      else $error("frame_end without run_last");

   // The byte position never runs past the longest burst.
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_HDR_SUM_HI)
      else $error("byte position out of range");

   // Once a frame closes, no samples remain outstanding.
   a_close_empty: assert property (@(posedge clock) disable iff (reset)
      emit_go && frame_end |=> samples_left_ff == '0)
      else $error("frame closed with samples left");

   // A new word is only taken when the item register frees up or is empty.
   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      req_acc && item_vld_ff |-> item_done)
      else $error("request accepted over a busy item");

endmodule

`default_nettype wire

>>> hw/rtl/cfpg_scale.sv
// ----------------------------------------------------------------------------
// cfpg_scale
// Applies the unsigned Q8.8 frame gain to one signed sample, truncating
// toward zero and saturating the result to -128..127.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpg_scale (
   input  wire logic [15:0]       gain,
   input  wire logic signed [7:0] sample,
   output logic [7:0]             scaled
);

   logic        neg;
   logic [7:0]  sample_u;
   logic [7:0]  mag;
   logic [23:0] prod;
   logic [15:0] q;
   logic [7:0]  q_sat;

   // Work on the magnitude so the shift truncates toward zero.
   assign neg      = sample[7];
   assign sample_u = sample;
   assign mag      = neg ? (8'd0 - sample_u) : sample_u;
   assign prod     = 24'(gain) * 24'(mag);
   assign q        = prod[23:8];

   // Saturate the magnitude, then restore the sign in two's complement.
   always_comb begin
      if (neg) begin
         q_sat  = (q > 16'd128) ? 8'd128 : q[7:0];
         scaled = 8'd0 - q_sat;
      end else begin
         q_sat  = (q > 16'd127) ? 8'd127 : q[7:0];
         scaled = q_sat;
      end
   end

endmodule

`default_nettype wire
